>>> hw/rtl/rlesz_pkg.sv
// Shared types and constants for the run-length sprite frame size counter.
`timescale 1ns / 1ps

package rlesz_pkg;

    // Width of the running pixel total; the result is its low 32 bits.
    localparam int TOTAL_WIDTH = 32;
    localparam int SIZE_WIDTH  = 32;

    // Pad bytes after every row header word.
    localparam logic [7:0] PAD_BYTES = 8'd4;

    // Parser phases
    localparam logic [2:0] PH_DONE   = 3'd0;
    localparam logic [2:0] PH_HDR_LO = 3'd1;
    localparam logic [2:0] PH_HDR_HI = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_CMD    = 3'd4;
    localparam logic [2:0] PH_FILL   = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;

    typedef struct packed {
        logic                  done;
        logic [SIZE_WIDTH-1:0] size;
    } rlesz_result_t;

endpackage

>>> hw/rtl/rle_sprite_frame_size_counter_top.sv
// Top level of the run-length sprite frame size counter.
`timescale 1ns / 1ps

// Takes the encoded row stream of one sprite frame a byte per transfer and
// returns the decoded pixel count (32-bit, wrapping) when the zero header
// word that ends the frame arrives. One byte is taken every cycle: each
// byte only updates the small parser state, and the result sits in an
// output register. The byte input stalls only while a result waits there
// and the result side is stalling. Assert frame_start on the first byte of
// a frame; bytes outside a frame are ignored.

module rle_sprite_frame_size_counter_top
    import rlesz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  logic                  frame_start,
    input  logic [7:0]            data_byte,
    output logic                  size_valid,
    input  logic                  size_stall,
    output logic [SIZE_WIDTH-1:0] frame_size
);

    logic                  size_valid_reg, size_valid_next;
    logic [SIZE_WIDTH-1:0] frame_size_reg;
    logic                  byte_xfer;
    rlesz_result_t         result;

    assign byte_stall = size_valid_reg & size_stall;
    assign byte_xfer  = byte_valid & ~byte_stall;

    rlesz_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (byte_xfer),
        .frame_start (frame_start),
        .data_byte   (data_byte),
        .result      (result)
    );

    always_comb
    begin
        size_valid_next = size_valid_reg & size_stall;
        if (byte_xfer && result.done)
            size_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_valid_reg <= 1'b0;
        else
            size_valid_reg <= size_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_xfer && result.done)
            frame_size_reg <= result.size;
    end

    assign size_valid = size_valid_reg;
    assign frame_size = frame_size_reg;

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> size_valid_reg && size_stall)
        else $error("byte side stalled without a held result");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        byte_xfer && result.done |=> size_valid_reg && frame_size_reg == $past(result.size))
        else $error("result not captured");

endmodule

>>> hw/rtl/rlesz_parser.sv
// Byte-wise row stream parser that accumulates the decoded pixel total.
`timescale 1ns / 1ps

module rlesz_parser
    import rlesz_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          frame_start,
    input  logic [7:0]    data_byte,
    output rlesz_result_t result
);

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             header_low_reg, header_low_next;
    logic [15:0]            runs_left_reg, runs_left_next;
    logic [14:0]            skip_reg, skip_next;
    logic                   in_run_reg, in_run_next;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;

    // Current state as seen by this byte; a frame start clears it first.
    logic [2:0]             ph_cur;
    logic [15:0]            runs_cur;
    logic [14:0]            skip_cur;
    logic                   in_run_cur;
    logic [TOTAL_WIDTH-1:0] total_cur;

    logic [15:0]            word;
    logic [6:0]             cmd_len;
    logic [7:0]             pad_dec;
    logic [14:0]            skip_dec;
    logic [15:0]            runs_sub;
    logic [2:0]             after_cmd;
    logic [63:0]            total_ext;

    always_comb
    begin
        ph_cur     = frame_start ? PH_HDR_LO : phase_reg;
        runs_cur   = frame_start ? 16'd0 : runs_left_reg;
        skip_cur   = frame_start ? 15'd0 : skip_reg;
        in_run_cur = frame_start ? 1'b0 : in_run_reg;
        total_cur  = frame_start ? '0 : total_reg;
    end

    assign word      = {data_byte, header_low_reg};
    assign cmd_len   = data_byte[7:1];
    assign pad_dec   = header_low_reg - 8'd1;
    assign skip_dec  = skip_cur - 15'd1;
    assign runs_sub  = runs_cur - 16'(cmd_len);
    assign total_ext = 64'(total_cur);

    always_comb
    begin
        phase_next      = ph_cur;
        header_low_next = header_low_reg;
        runs_left_next  = runs_cur;
        skip_next       = skip_cur;
        in_run_next     = in_run_cur;
        total_next      = total_cur;
        result.done     = 1'b0;
        result.size     = total_ext[SIZE_WIDTH-1:0];
        after_cmd       = (runs_cur != 16'd0) ? PH_CMD : PH_HDR_LO;

        case (ph_cur)
            PH_HDR_LO:
            begin
                header_low_next = data_byte;
                phase_next      = PH_HDR_HI;
            end
            PH_HDR_HI:
            begin
                if (word == 16'd0)
                begin
                    phase_next  = PH_DONE;
                    result.done = 1'b1;
                end
                else
                begin
                    if (word[0])
                    begin
                        in_run_next    = 1'b1;
                        runs_left_next = {1'b0, word[15:1]};
                    end
                    else
                    begin
                        in_run_next = 1'b0;
                        skip_next   = word[15:1];
                        total_next  = total_cur + TOTAL_WIDTH'(word[15:1]);
                    end
                    header_low_next = PAD_BYTES;
                    phase_next      = PH_PAD;
                end
            end
            PH_PAD:
            begin
                header_low_next = pad_dec;
                if (pad_dec == 8'd0)
                begin
                    if (in_run_cur)
                        phase_next = after_cmd;
                    else
                        phase_next = (skip_cur != 15'd0) ? PH_SKIP : PH_HDR_LO;
                end
            end
            PH_CMD:
            begin
                runs_left_next = runs_sub;
                total_next     = total_cur + TOTAL_WIDTH'(cmd_len);
                if (data_byte[0])
                    phase_next = PH_FILL;
                else if (cmd_len != 7'd0)
                begin
                    skip_next  = 15'(cmd_len);
                    phase_next = PH_SKIP;
                end
                else
                    phase_next = (runs_sub != 16'd0) ? PH_CMD : PH_HDR_LO;
            end
            PH_FILL:
            begin
                phase_next = after_cmd;
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 15'd0)
                    phase_next = in_run_cur ? after_cmd : PH_HDR_LO;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DONE;
            header_low_reg <= 8'd0;
            runs_left_reg  <= 16'd0;
            skip_reg       <= 15'd0;
            in_run_reg     <= 1'b0;
            total_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            header_low_reg <= header_low_next;
            runs_left_reg  <= runs_left_next;
            skip_reg       <= skip_next;
            in_run_reg     <= in_run_next;
            total_reg      <= total_next;
        end
    end

    a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.done |=> phase_reg == PH_DONE)
        else $error("parser not idle after frame end");

    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> header_low_reg != 8'd0 && header_low_reg <= PAD_BYTES)
        else $error("pad countdown out of range");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_reg != 15'd0)
        else $error("skip phase with nothing to skip");

    a_cmd_runs: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CMD |-> in_run_reg && runs_left_reg != 16'd0)
        else $error("command phase outside a live run row");

endmodule

>>> test/tb_rle_sprite_frame_size_counter_top.sv
// Testbench for the run-length sprite frame size counter top level.
`timescale 1ns / 1ps

module tb_rle_sprite_frame_size_counter_top;
    import rlesz_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_RUN_STEP  = 127;
    localparam int RANDOM_ITEMS  = 400;
    localparam int RANDOM_FRAMES = 20;

    logic                  clk;
    logic                  rst_n;
    logic                  byte_valid;
    logic                  byte_stall;
    logic                  frame_start;
    logic [7:0]            data_byte;
    logic                  size_valid;
    logic                  size_stall;
    logic [SIZE_WIDTH-1:0] frame_size;

    // Parser state mirrored on the testbench side
    logic [2:0]             parser_phase;
    logic [7:0]             hdr_low;
    logic [15:0]            runs_left;
    logic [14:0]            skip_left;
    logic                   run_row;
    logic [TOTAL_WIDTH-1:0] pixel_total;

    logic [SIZE_WIDTH-1:0] expected_sizes[$];
    logic [SIZE_WIDTH-1:0] want_size;
    logic [7:0]            frame_bytes[$];

    int  fail_count;
    int  bytes_sent;
    int  sizes_checked;
    int  frames_ended;
    int  burst_left;
    bit  bursty;
    bit  hold_request;

    rle_sprite_frame_size_counter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .frame_start (frame_start),
        .data_byte   (data_byte),
        .size_valid  (size_valid),
        .size_stall  (size_stall),
        .frame_size  (frame_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        parser_phase = PH_DONE;
        hdr_low      = '0;
        runs_left    = '0;
        skip_left    = '0;
        run_row      = 1'b0;
        pixel_total  = '0;
    endfunction

    function automatic logic [2:0] phase_after_command();
        return (runs_left != 0) ? PH_CMD : PH_HDR_LO;
    endfunction

    // Steps the mirrored parser by one accepted byte; queues a size when a frame ends.
    function automatic void advance_parser(input logic start, input logic [7:0] b);
        logic [15:0] word;
        logic [6:0]  n;
        if (start)
        begin
            clear_parser();
            parser_phase = PH_HDR_LO;
        end
        word = {b, hdr_low};
        n    = b[7:1];
        case (parser_phase)
            PH_HDR_LO:
            begin
                hdr_low      = b;
                parser_phase = PH_HDR_HI;
            end
            PH_HDR_HI:
            begin
                if (word == 16'h0000)
                begin
                    parser_phase = PH_DONE;
                    expected_sizes.push_back(SIZE_WIDTH'(pixel_total));
                    frames_ended++;
                end
                else
                begin
                    if (word[0])
                    begin
                        run_row   = 1'b1;
                        runs_left = {1'b0, word[15:1]};
                    end
                    else
                    begin
                        run_row     = 1'b0;
                        skip_left   = word[15:1];
                        pixel_total = pixel_total + skip_left;
                    end
                    hdr_low      = PAD_BYTES;
                    parser_phase = PH_PAD;
                end
            end
            PH_PAD:
            begin
                hdr_low = hdr_low - 8'd1;
                if (hdr_low == 8'd0)
                begin
                    if (run_row)
                        parser_phase = phase_after_command();
                    else
                        parser_phase = (skip_left != 0) ? PH_SKIP : PH_HDR_LO;
                end
            end
            PH_CMD:
            begin
                runs_left   = runs_left - n;
                pixel_total = pixel_total + n;
                if (b[0])
                    parser_phase = PH_FILL;
                else if (n != 0)
                begin
                    skip_left    = 15'(n);
                    parser_phase = PH_SKIP;
                end
                else
                    parser_phase = phase_after_command();
            end
            PH_FILL:
                parser_phase = phase_after_command();
            PH_SKIP:
            begin
                skip_left = skip_left - 15'd1;
                if (skip_left == 0)
                    parser_phase = run_row ? phase_after_command() : PH_HDR_LO;
            end
            default:
                parser_phase = PH_DONE;
        endcase
    endfunction

    // Row header word followed by its pad bytes
    function automatic void push_header(input logic [15:0] word);
        frame_bytes.push_back(word[7:0]);
        frame_bytes.push_back(word[15:8]);
        repeat (PAD_BYTES) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_raw_row(input int len);
        push_header({15'(len), 1'b0});
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Run row whose commands add up exactly to the count
    function automatic void push_run_row(input int count, input int max_step);
        int   remaining;
        int   step;
        logic fill;
        push_header({15'(count), 1'b1});
        remaining = count;
        while (remaining > 0)
        begin
            step = $urandom_range(0, (remaining < max_step) ? remaining : max_step);
            fill = 1'($urandom_range(0, 1));
            frame_bytes.push_back({7'(step), fill});
            if (fill)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            else
                repeat (step) frame_bytes.push_back(8'($urandom_range(0, 255)));
            remaining -= step;
        end
    endfunction

    function automatic void push_frame_end();
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h00);
    endfunction

    task automatic send_byte(input logic start, input logic [7:0] b);
        int gap;
        if (bursty && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
            @(negedge clk);
            byte_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        byte_valid  <= 1'b1;
        frame_start <= start;
        data_byte   <= b;
        do
            @(posedge clk);
        while (byte_stall);
        bytes_sent++;
        advance_parser(start, b);
    endtask

    task automatic send_frame_bytes();
        foreach (frame_bytes[i])
            send_byte(i == 0, frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic drain_sizes();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (expected_sizes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_bytes_and_empty_frame();
        bursty = 1'b0;
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        push_frame_end();
        send_frame_bytes();
        send_byte(1'b0, 8'h01);
        drain_sizes();
    endtask

    task automatic test_row_kinds();
        bursty = 1'b1;
        // raw row of 3, run row of 5 (fill, empty literal, empty fill, literal), empty run row
        frame_bytes = '{8'h06, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55,
                        8'hFF, 8'h00, 8'h7F,
                        8'h0B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h05, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h06, 8'h01, 8'h02, 8'h03,
                        8'h01, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44,
                        8'h00, 8'h00};
        send_frame_bytes();
        drain_sizes();
    endtask

    task automatic test_restart_mid_frame();
        bursty = 1'b0;
        frame_bytes = '{8'h10, 8'h00, 8'h00, 8'h00};
        send_frame_bytes();
        push_frame_end();
        send_frame_bytes();
        // drop a frame in the middle of a fill command
        push_header(16'h0021);
        frame_bytes.push_back(8'h09);
        send_frame_bytes();
        push_raw_row(2);
        push_frame_end();
        send_frame_bytes();
        drain_sizes();
    endtask

    task automatic test_count_wrap();
        bursty = 1'b1;
        // one run, then a literal of two takes the count below zero to 65535;
        // the two zero bytes after it are still empty commands, so no size is due
        push_header(16'h0003);
        frame_bytes.push_back(8'h04);
        frame_bytes.push_back(8'hC3);
        frame_bytes.push_back(8'h3C);
        push_frame_end();
        send_frame_bytes();
        drain_sizes();
    endtask

    task automatic test_largest_headers();
        bursty = 1'b1;
        // largest run count, covered by the longest fills
        push_header(16'hFFFF);
        repeat (258)
        begin
            frame_bytes.push_back(8'hFF);
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        frame_bytes.push_back(8'h03);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        push_frame_end();
        send_frame_bytes();
        drain_sizes();
    endtask

    task automatic test_output_backpressure();
        bursty = 1'b0;
        hold_request = 1'b1;
        repeat (6)
        begin
            push_frame_end();
            send_frame_bytes();
            push_raw_row($urandom_range(1, 3));
            push_frame_end();
            send_frame_bytes();
        end
        drain_sizes();
    endtask

    task automatic test_random_frames();
        int items;
        int ended_at_start;
        int rows;
        int cut;
        int pick;
        items          = 0;
        ended_at_start = frames_ended;
        while (items < RANDOM_ITEMS || frames_ended - ended_at_start < RANDOM_FRAMES)
        begin
            bursty = ($urandom_range(0, 3) != 0);
            pick   = $urandom_range(0, 99);
            if (pick < 5)
            begin
                // stray bytes without a frame start
                repeat ($urandom_range(1, 5))
                    send_byte(1'b0, 8'($urandom_range(0, 255)));
            end
            else if (pick < 15)
            begin
                repeat ($urandom_range(1, 10))
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                items += frame_bytes.size();
                send_frame_bytes();
            end
            else
            begin
                rows = $urandom_range(0, 3);
                repeat (rows)
                begin
                    case ($urandom_range(0, 9))
                        0:       push_run_row(0, MAX_RUN_STEP);
                        1, 2, 3: push_raw_row(($urandom_range(0, 19) == 0) ?
                                              $urandom_range(1, 400) : $urandom_range(1, 8));
                        default: push_run_row(($urandom_range(0, 19) == 0) ?
                                              $urandom_range(1, 300) : $urandom_range(1, 16),
                                              MAX_RUN_STEP);
                    endcase
                end
                push_frame_end();
                if (pick < 25)
                begin
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    frame_bytes = frame_bytes[0:cut-1];
                end
                items += frame_bytes.size();
                send_frame_bytes();
            end
        end
        drain_sizes();
    endtask

    // Result side: stall pattern in segments, plus one long hold-off on request
    initial
    begin : size_receiver
        int seg_len;
        int stall_pct;
        size_stall = 1'b0;
        forever
        begin
            seg_len = $urandom_range(8, 80);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (seg_len)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    size_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_request = 1'b0;
                end
                size_stall <= ($urandom_range(1, 100) <= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && size_valid && !size_stall)
        begin
            sizes_checked++;
            if (expected_sizes.size() == 0)
            begin
                if (fail_count < 10)
                    $display("ERROR: frame_size 0x%08h transferred with no frame pending",
                             frame_size);
                fail_count++;
            end
            else
            begin
                want_size = expected_sizes.pop_front();
                if (frame_size !== want_size)
                begin
                    if (fail_count < 10)
                        $display("ERROR: frame_size expected %0d (0x%08h), got %0d (0x%08h)",
                                 want_size, want_size, frame_size, frame_size);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (size_valid && !size_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        frame_start  = 1'b0;
        data_byte    = 8'h00;
        hold_request = 1'b0;
        bursty       = 1'b0;
        burst_left   = 0;
        fail_count   = 0;
        bytes_sent   = 0;
        sizes_checked = 0;
        frames_ended = 0;
        clear_parser();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_bytes_and_empty_frame();
        test_row_kinds();
        test_restart_mid_frame();
        test_count_wrap();
        test_largest_headers();
        test_output_backpressure();
        test_random_frames();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run: %0d bytes transferred, %0d frame sizes checked, %0d failures.",
                 bytes_sent, sizes_checked, fail_count);
        $display("Covered raw, fill, literal and empty rows, restarts, count wrap, "
                 , "the largest run header and a long hold-off on the result side.");
        if (fail_count == 0 && expected_sizes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rlesz_pkg.sv
hw/rtl/rlesz_parser.sv
hw/rtl/rle_sprite_frame_size_counter_top.sv
test/tb_rle_sprite_frame_size_counter_top.sv
